FILE: rtl/sct_pkg.sv
package sct_pkg;

  localparam int MAX_TERMS_DEF = 20;
  localparam int FRAC_BITS_DEF = 30;

  localparam int ANGLE_W    = 32;
  localparam int ANGLE_FRAC = 24;
  localparam int OUT_W      = 32;
  localparam int OUT_FRAC   = 30;
  localparam int THR_W      = 10;

  localparam logic [THR_W-1:0] THR_RESET  = 10'd1;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q24 = 32'd105414357;

  // |angle| <= 2^31 holds at most 20 periods, so five conditional
  // subtractions of 16, 8, 4, 2 and 1 periods finish the reduction.
  localparam int RED_STAGES = 5;

  // Widest product and magnitude that any legal fraction width produces.
  localparam int WIDE_W = 96;
  localparam int MAG_W  = 48;

  // Rounds a product half up, drops frac fraction bits and saturates.
  function automatic logic [MAG_W-1:0] round_sat(input logic [WIDE_W-1:0] prod,
                                                 input int frac,
                                                 input logic [MAG_W-1:0] lim);
    logic [WIDE_W:0] r;
    r = ({1'b0, prod} + ((WIDE_W+1)'(1) << (frac - 1))) >> frac;
    if (r > {{(WIDE_W+1-MAG_W){1'b0}}, lim}) begin
      round_sat = lim;
    end else begin
      round_sat = r[MAG_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/sct_mul.sv
module sct_mul #(
  parameter int AW = 38,
  parameter int BW = 38
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll_r;
  logic [AL+BH-1:0] plh_r;
  logic [AH+BL-1:0] phl_r;
  logic [AH+BH-1:0] phh_r;
  logic [PW-1:0]    p_r;

  // Four half-width partial products, summed in the following cycle.
  always_ff @(posedge clk) begin
    if (ce) begin
      pll_r <= a[AL-1:0]  * b[BL-1:0];
      plh_r <= a[AL-1:0]  * b[BW-1:BL];
      phl_r <= a[AW-1:AL] * b[BL-1:0];
      phh_r <= a[AW-1:AL] * b[BW-1:BL];
      p_r   <= PW'(pll_r) + (PW'(plh_r) << BL) + (PW'(phl_r) << AL)
               + (PW'(phh_r) << (AL + BL));
    end
  end

  assign p = p_r;

endmodule

FILE: rtl/sct_range.sv
module sct_range #(
  parameter int FRAC_BITS = sct_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [sct_pkg::ANGLE_W-1:0]   in_angle,
  output logic                          out_valid,
  output logic                          out_neg,
  output logic [FRAC_BITS+7:0]          out_xm,
  output logic [FRAC_BITS+7:0]          out_x2
);

  localparam int IW  = FRAC_BITS + 8;
  localparam int R   = sct_pkg::RED_STAGES;
  localparam int AW  = sct_pkg::ANGLE_W;
  localparam int LAT = R + 4;
  localparam logic [IW-1:0] LIM = '1;

  logic [LAT-1:0] vld_r;
  logic           neg_r [LAT];
  logic [AW-1:0]  mag_r [R];
  logic [AW-1:0]  mag_nxt [R];
  logic [IW-1:0]  xm_r [3];
  logic [IW-1:0]  xm_nxt;
  logic [IW-1:0]  x2_r;
  logic [2*IW-1:0] sq;
  logic [AW-1:0]  mag0;

  assign mag0 = in_angle[AW-1] ? (~in_angle + AW'(1)) : in_angle;

  always_comb begin
    logic [AW-1:0] src;
    logic [AW-1:0] step;
    for (int i = 0; i < R; i++) begin
      src  = (i == 0) ? mag0 : mag_r[(i == 0) ? 0 : i - 1];
      step = sct_pkg::TWO_PI_Q24 << (R - 1 - i);
      mag_nxt[i] = (src >= step) ? (src - step) : src;
    end
  end

  if (FRAC_BITS >= sct_pkg::ANGLE_FRAC) begin : g_xm_up
    assign xm_nxt = IW'(mag_r[R-1]) << (FRAC_BITS - sct_pkg::ANGLE_FRAC);
  end else begin : g_xm_down
    assign xm_nxt = IW'((33'(mag_r[R-1]) + (33'(1) << (sct_pkg::ANGLE_FRAC - FRAC_BITS - 1)))
                        >> (sct_pkg::ANGLE_FRAC - FRAC_BITS));
  end

  sct_mul #(.AW(IW), .BW(IW)) u_sq (
    .clk (clk),
    .ce  (ce),
    .a   (xm_r[0]),
    .b   (xm_r[0]),
    .p   (sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
    if (ce) begin
      neg_r[0] <= in_angle[AW-1];
      for (int i = 1; i < LAT; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 0; i < R; i++) begin
        mag_r[i] <= mag_nxt[i];
      end
      xm_r[0] <= xm_nxt;
      xm_r[1] <= xm_r[0];
      xm_r[2] <= xm_r[1];
      x2_r    <= IW'(sct_pkg::round_sat(sct_pkg::WIDE_W'(sq), FRAC_BITS,
                                        sct_pkg::MAG_W'(LIM)));
    end
  end

  // xm_r[2] matches the squarer output; xm_out_r aligns it with x2_r.
  logic [IW-1:0] xm_out_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      xm_out_r <= xm_r[2];
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_neg   = neg_r[LAT-1];
  assign out_xm    = xm_out_r;
  assign out_x2    = x2_r;

endmodule

FILE: rtl/sct_term.sv
module sct_term #(
  parameter int FRAC_BITS = sct_pkg::FRAC_BITS_DEF,
  parameter int N         = 3,
  parameter bit SUBTRACT  = 1'b1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic [sct_pkg::THR_W-1:0]       thr,
  input  logic                            in_valid,
  input  logic                            in_done,
  input  logic                            in_neg,
  input  logic [FRAC_BITS+7:0]            in_tmag,
  input  logic signed [FRAC_BITS+9:0]     in_sum,
  input  logic [FRAC_BITS+7:0]            in_x2,
  output logic                            out_valid,
  output logic                            out_done,
  output logic                            out_neg,
  output logic [FRAC_BITS+7:0]            out_tmag,
  output logic signed [FRAC_BITS+9:0]     out_sum,
  output logic [FRAC_BITS+7:0]            out_x2
);

  localparam int IW = FRAC_BITS + 8;
  localparam int SW = IW + 2;
  localparam int VW = IW + 1;
  localparam int S  = VW;
  localparam int TW = IW + sct_pkg::OUT_FRAC;
  localparam int K  = N * (N - 1);
  localparam int LS = 8;
  localparam longint unsigned M_VAL = (64'd1 << S) / K;
  localparam logic [S-1:0]  RECIP = S'(M_VAL);
  localparam logic [VW-1:0] K_V   = VW'(K);
  localparam logic [VW-1:0] K_HALF = VW'(K / 2);
  localparam logic [IW-1:0] LIM = '1;
  localparam logic signed [SW-1:0] LIM_S = {2'b00, LIM};

  logic [TW-1:0] tq;
  logic          act;

  if (FRAC_BITS >= sct_pkg::OUT_FRAC) begin : g_tq_down
    assign tq = TW'(in_tmag >> (FRAC_BITS - sct_pkg::OUT_FRAC));
  end else begin : g_tq_up
    assign tq = TW'(in_tmag) << (sct_pkg::OUT_FRAC - FRAC_BITS);
  end

  // A series that stopped stays stopped: the term it compares never changes.
  assign act = !in_done && (tq >= TW'(thr));

  logic [LS-1:0]        vld_r;
  logic                 act_r  [LS];
  logic                 neg_r  [LS];
  logic [IW-1:0]        tmag_r [LS];
  logic signed [SW-1:0] sum_r  [LS];
  logic [IW-1:0]        x2_r   [LS];

  logic [2*IW-1:0]  prod;
  logic [VW+S-1:0]  prod_q;
  logic [VW-1:0]    v_r [5];
  logic [VW-1:0]    qe_r;
  logic [VW-1:0]    qe7_r;
  logic [VW-1:0]    qk_r;
  logic [IW-1:0]    q_r;
  logic [VW-1:0]    rem;
  logic [IW-1:0]    q_nxt;

  sct_mul #(.AW(IW), .BW(IW)) u_term_mul (
    .clk (clk),
    .ce  (ce),
    .a   (in_tmag),
    .b   (in_x2),
    .p   (prod)
  );

  // Division by n*(n-1): reciprocal multiply, then one correction step.
  sct_mul #(.AW(VW), .BW(S)) u_recip_mul (
    .clk (clk),
    .ce  (ce),
    .a   (v_r[0]),
    .b   (RECIP),
    .p   (prod_q)
  );

  assign rem   = v_r[4] - qk_r;
  assign q_nxt = (rem >= K_V) ? IW'(qe7_r + VW'(1)) : IW'(qe7_r);

  logic                 sub;
  logic signed [SW-1:0] q_s;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] sum_clamp;

  assign sub     = SUBTRACT ^ neg_r[LS-1];
  assign q_s     = $signed({2'b00, q_r});
  assign sum_nxt = sub ? (sum_r[LS-1] - q_s) : (sum_r[LS-1] + q_s);

  always_comb begin
    if (sum_nxt > LIM_S) begin
      sum_clamp = LIM_S;
    end else if (sum_nxt < -LIM_S) begin
      sum_clamp = -LIM_S;
    end else begin
      sum_clamp = sum_nxt;
    end
  end

  logic                 vld_o_r;
  logic                 done_o_r;
  logic                 neg_o_r;
  logic [IW-1:0]        tmag_o_r;
  logic signed [SW-1:0] sum_o_r;
  logic [IW-1:0]        x2_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_o_r <= 1'b0;
    end else if (ce) begin
      vld_r   <= {vld_r[LS-2:0], in_valid};
      vld_o_r <= vld_r[LS-1];
    end
    if (ce) begin
      act_r[0]  <= act;
      neg_r[0]  <= in_neg;
      tmag_r[0] <= in_tmag;
      sum_r[0]  <= in_sum;
      x2_r[0]   <= in_x2;
      for (int i = 1; i < LS; i++) begin
        act_r[i]  <= act_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        tmag_r[i] <= tmag_r[i-1];
        sum_r[i]  <= sum_r[i-1];
        x2_r[i]   <= x2_r[i-1];
      end
      v_r[0] <= VW'(sct_pkg::round_sat(sct_pkg::WIDE_W'(prod), FRAC_BITS,
                                       sct_pkg::MAG_W'(LIM))) + K_HALF;
      for (int i = 1; i < 5; i++) begin
        v_r[i] <= v_r[i-1];
      end
      qe_r  <= prod_q[VW+S-1:S];
      qe7_r <= qe_r;
      qk_r  <= VW'(qe_r * K_V);
      q_r   <= q_nxt;

      done_o_r <= !act_r[LS-1];
      neg_o_r  <= neg_r[LS-1];
      x2_o_r   <= x2_r[LS-1];
      tmag_o_r <= act_r[LS-1] ? q_r : tmag_r[LS-1];
      sum_o_r  <= act_r[LS-1] ? sum_clamp : sum_r[LS-1];
    end
  end

  assign out_valid = vld_o_r;
  assign out_done  = done_o_r;
  assign out_neg   = neg_o_r;
  assign out_tmag  = tmag_o_r;
  assign out_sum   = sum_o_r;
  assign out_x2    = x2_o_r;

endmodule

FILE: rtl/sine_cosine_taylor.sv
// Sine and cosine of a signed Q8.24 angle in radians, each as signed Q2.30
// saturated to plus or minus one, packed into one output beat. The angle is
// reduced modulo 2*pi keeping its sign, then both Taylor series are summed in
// a fixed pipeline of MAX_TERMS-1 term units per series; a series whose term
// falls below stop_threshold simply passes through its remaining units.
// Every item passes through the range reduction, the term units of both
// series and an output register; each term unit has nine stages (two split
// multiplications and a reciprocal division). A new beat is taken every
// cycle while the output is not stalled. Write stop_threshold only while no
// beat is in flight.
module sine_cosine_taylor #(
  parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = sct_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [sct_pkg::THR_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,    // [31:0] angle
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata    // [31:0] sine, [63:32] cosine
);

  localparam int IW = FRAC_BITS + 8;
  localparam int SW = IW + 2;
  localparam int T  = MAX_TERMS - 1;
  localparam int EW = IW + 16;
  localparam int SH = FRAC_BITS - sct_pkg::OUT_FRAC;
  localparam logic [EW-1:0] ONE_OUT = EW'(1) << sct_pkg::OUT_FRAC;

  logic [sct_pkg::THR_W-1:0] stop_threshold_r;
  logic ce;

  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_threshold_r <= sct_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      stop_threshold_r <= cfg_wdata;
    end
  end

  logic          rng_vld;
  logic          rng_neg;
  logic [IW-1:0] rng_xm;
  logic [IW-1:0] rng_x2;

  sct_range #(.FRAC_BITS(FRAC_BITS)) u_range (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .in_angle  (in_tdata),
    .out_valid (rng_vld),
    .out_neg   (rng_neg),
    .out_xm    (rng_xm),
    .out_x2    (rng_x2)
  );

  // Index 0 is sine, index 1 is cosine.
  logic                 c_vld  [2][T+1];
  logic                 c_done [2][T+1];
  logic                 c_neg  [2][T+1];
  logic [IW-1:0]        c_tmag [2][T+1];
  logic signed [SW-1:0] c_sum  [2][T+1];
  logic [IW-1:0]        c_x2   [2][T+1];

  assign c_vld[0][0]  = rng_vld;
  assign c_done[0][0] = 1'b0;
  assign c_neg[0][0]  = rng_neg;
  assign c_tmag[0][0] = rng_xm;
  assign c_sum[0][0]  = rng_neg ? -$signed(SW'(rng_xm)) : $signed(SW'(rng_xm));
  assign c_x2[0][0]   = rng_x2;

  assign c_vld[1][0]  = rng_vld;
  assign c_done[1][0] = 1'b0;
  assign c_neg[1][0]  = 1'b0;
  assign c_tmag[1][0] = IW'(1) << FRAC_BITS;
  assign c_sum[1][0]  = $signed(SW'(1) << FRAC_BITS);
  assign c_x2[1][0]   = rng_x2;

  for (genvar s = 0; s < 2; s++) begin : g_series
    for (genvar j = 0; j < T; j++) begin : g_term
      sct_term #(
        .FRAC_BITS (FRAC_BITS),
        .N         ((1 - s) + 2 * (j + 1)),
        .SUBTRACT  ((j % 2) == 0)
      ) u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .thr       (stop_threshold_r),
        .in_valid  (c_vld[s][j]),
        .in_done   (c_done[s][j]),
        .in_neg    (c_neg[s][j]),
        .in_tmag   (c_tmag[s][j]),
        .in_sum    (c_sum[s][j]),
        .in_x2     (c_x2[s][j]),
        .out_valid (c_vld[s][j+1]),
        .out_done  (c_done[s][j+1]),
        .out_neg   (c_neg[s][j+1]),
        .out_tmag  (c_tmag[s][j+1]),
        .out_sum   (c_sum[s][j+1]),
        .out_x2    (c_x2[s][j+1])
      );
    end
  end

  logic [31:0] res [2];

  for (genvar s = 0; s < 2; s++) begin : g_out
    logic          neg;
    logic [EW-1:0] m;
    logic [EW-1:0] sc;
    logic [EW-1:0] sat;
    assign neg = c_sum[s][T][SW-1];
    assign m   = EW'(neg ? -c_sum[s][T] : c_sum[s][T]);
    if (SH > 0) begin : g_rnd
      assign sc = (m + (EW'(1) << (SH - 1))) >> SH;
    end else begin : g_shl
      assign sc = m << (-SH);
    end
    assign sat    = (sc > ONE_OUT) ? ONE_OUT : sc;
    assign res[s] = neg ? (32'd0 - sat[31:0]) : sat[31:0];
  end

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      out_tvalid_r <= c_vld[0][T];
    end
    if (ce) begin
      out_tdata_r <= {res[1], res[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= 32'sd1073741824 &&
                    $signed(out_tdata[31:0]) >= -32'sd1073741824))
    else $error("sine beyond unit magnitude");

  a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[63:32]) <= 32'sd1073741824 &&
                    $signed(out_tdata[63:32]) >= -32'sd1073741824))
    else $error("cosine beyond unit magnitude");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> ($stable(rng_vld) && $stable(c_vld[0][T])))
    else $error("pipeline moved during an output stall");

  a_series_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld[0][T] == c_vld[1][T])
    else $error("sine and cosine series out of step");

  a_thr_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> stop_threshold_r == sct_pkg::THR_RESET)
    else $error("threshold not at its reset value");

endmodule
